/* hw/rtl/tfdc_pkg.sv */
package tfdc_pkg;

  // PWM period of the fan output, in timer counts.
  localparam int FAN_PERIOD = 1000;

  // Accumulator and dividend width: wide enough for the last interpolation numerator.
  localparam int DW  = 54;
  // Signed distance between a knot and a sample.
  localparam int XW  = 13;
  // Signed divisor width and divisor magnitude width.
  localparam int DVW = 17;
  localparam int DMW = 16;
  // Saturated temperature, duty percent, and step counter widths.
  localparam int TW  = 17;
  localparam int PW  = 24;
  localparam int CW  = 6;
  // Widths of the first and second interpolation levels.
  localparam int AW  = 27;
  localparam int BW  = 40;
  localparam int SW  = 12;
  localparam int IN_W  = 24;
  localparam int OUT_W = 32;
  localparam int DEG_W = 10;
  localparam int CMP_W = 16;
  localparam int PCT_CFG_W = 7;

  localparam logic signed [DW-1:0] KNOT_T0 = DW'(2500);
  localparam logic signed [DW-1:0] KNOT_T1 = DW'(5000);
  localparam logic signed [DW-1:0] KNOT_T2 = DW'(8000);
  localparam logic signed [DW-1:0] KNOT_T3 = DW'(12500);

  localparam logic signed [DW-1:0] TEMP_MIN = -DW'(20000);
  localparam logic signed [DW-1:0] TEMP_MAX = DW'(40000);
  localparam logic signed [DVW-1:0] DEG_DIV = DVW'(100);
  localparam logic signed [DVW-1:0] CC_DIV  = DVW'(200);
  localparam logic signed [DW-1:0] CC_LO = DW'(5);
  localparam logic signed [DW-1:0] CC_HI = DW'(FAN_PERIOD / 2 - 5);
  localparam logic signed [DVW-1:0] PERIOD_S = DVW'(FAN_PERIOD);

  localparam logic [2:0] CFG_KNOT0    = 3'd0;
  localparam logic [2:0] CFG_KNOT1    = 3'd1;
  localparam logic [2:0] CFG_KNOT2    = 3'd2;
  localparam logic [2:0] CFG_KNOT3    = 3'd3;
  localparam logic [2:0] CFG_PCT_MIN  = 3'd4;
  localparam logic [2:0] CFG_PCT_MAX  = 3'd5;
  localparam logic [2:0] CFG_TEMP_LOW = 3'd6;
  localparam logic [2:0] CFG_TEMP_HI  = 3'd7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_DLOAD,
    ST_DIV,
    ST_WB,
    ST_OUT
  } state_t;

  typedef enum logic [3:0] {
    OP_A3,
    OP_A2,
    OP_A1,
    OP_B3,
    OP_B2,
    OP_C,
    OP_DEG,
    OP_PCT,
    OP_CC
  } op_t;

  // Quotient bits needed by each division: the numerator magnitude stays below 2^n.
  function automatic logic [CW-1:0] div_bits(input op_t op);
    logic [CW-1:0] n;
    case (op)
      OP_A3, OP_A2, OP_A1: n = CW'(26);
      OP_B3, OP_B2:        n = CW'(39);
      OP_C:                n = CW'(52);
      OP_DEG:              n = CW'(16);
      OP_PCT:              n = CW'(23);
      OP_CC:               n = CW'(39);
      default:             n = CW'(52);
    endcase
    return n;
  endfunction

  function automatic logic op_has_mul(input op_t op);
    logic m;
    case (op)
      OP_A3, OP_A2, OP_A1, OP_B3, OP_B2, OP_C: m = 1'b1;
      default:                                 m = 1'b0;
    endcase
    return m;
  endfunction

endpackage

/* hw/rtl/thermal_fan_duty_controller.sv */
// Each accepted item runs the interpolation for both samples, then the degree division; when
// warmed_up is set, the duty division follows if the temperature lies between the thresholds,
// and the compare division ends every warm item; a zero divisor skips its division.
// One item at a time: the next item is taken the cycle after the result is registered. One
// shared shift-add multiplier and one restoring divider, each one bit per cycle, set how long
// each item takes. Reset (rst_n low, synchronous) loads the default knots and thresholds,
// clears the fan compare value and empties the output register.
module thermal_fan_duty_controller
  import tfdc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // sensor_a_sample [11:0], sensor_b_sample [23:12]
  input  logic             in_tuser,   // warmed_up
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata,  // temperature_deg [9:0], fan_compare [25:10], zeros
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [2:0]       cfg_index,
  input  logic [15:0]      cfg_data
);

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;

  logic [SW-1:0] k0_r, k0_nxt, k1_r, k1_nxt, k2_r, k2_nxt, k3_r, k3_nxt;
  logic [PCT_CFG_W-1:0] pmin_r, pmin_nxt, pmax_r, pmax_nxt;
  logic [15:0] tl_r, tl_nxt, th_r, th_nxt;
  logic [CMP_W-1:0] cmp_r, cmp_nxt;
  logic out_tvalid_r, out_tvalid_nxt;

  logic [SW-1:0] samp_a_r, samp_a_nxt, samp_b_r, samp_b_nxt;
  logic warm_r, warm_nxt, sel_r, sel_nxt;
  logic signed [AW-1:0] a1_r, a1_nxt, a2_r, a2_nxt, a3_r, a3_nxt;
  logic signed [BW-1:0] b2_r, b2_nxt, b3_r, b3_nxt;
  logic signed [DW-1:0] ta_r, ta_nxt;
  logic signed [TW-1:0] t_r, t_nxt;
  logic signed [DEG_W-1:0] deg_r, deg_nxt;
  logic signed [PW-1:0] pct_r, pct_nxt;
  logic signed [DW-1:0] mp_r, mp_nxt, mq_r, mq_nxt, acc_r, acc_nxt;
  logic [XW-1:0] mu_r, mu_nxt, mv_r, mv_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [DW-1:0] quo_r, quo_nxt;
  logic [DMW-1:0] rem_r, rem_nxt, dmag_r, dmag_nxt;
  logic neg_r, neg_nxt, dz_r, dz_nxt;
  logic signed [DEG_W-1:0] out_deg_r, out_deg_nxt;
  logic [CMP_W-1:0] out_cmp_r, out_cmp_nxt;

  logic [SW-1:0] x;
  logic signed [XW-1:0] d0, d1, d2, d3;
  logic signed [XW-1:0] u_sel, v_sel;
  logic signed [DW-1:0] p_sel, q_sel, num_direct;
  logic signed [DVW-1:0] den;
  logic signed [TW:0] t_minus_tl, t_minus_th;
  logic signed [7:0] dpct;
  logic signed [25:0] pct_prod;
  logic signed [PW+DVW-1:0] cc_prod;
  logic [CW-1:0] nb;
  logic t_below, t_above, wb_done, out_free;
  logic signed [DW-1:0] addp, addq, res, tmax, tsat, cc1, cc2;
  logic [DW-1:0] mag;
  logic [DMW:0] sh;
  logic [DMW+1:0] diff;
  logic ge;
  logic [CW-1:0] dshift;
  logic signed [DVW-1:0] dneg;

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {(OUT_W - DEG_W - CMP_W)'(0), out_cmp_r, out_deg_r};

  assign x  = sel_r ? samp_b_r : samp_a_r;
  assign d0 = $signed({1'b0, k0_r}) - $signed({1'b0, x});
  assign d1 = $signed({1'b0, k1_r}) - $signed({1'b0, x});
  assign d2 = $signed({1'b0, k2_r}) - $signed({1'b0, x});
  assign d3 = $signed({1'b0, k3_r}) - $signed({1'b0, x});

  assign t_minus_tl = $signed({t_r[TW-1], t_r}) - $signed({2'b00, tl_r});
  assign t_minus_th = $signed({t_r[TW-1], t_r}) - $signed({2'b00, th_r});
  assign t_below    = t_minus_tl[TW];
  assign t_above    = !t_minus_th[TW] && (t_minus_th != '0);
  assign dpct       = $signed({1'b0, pmax_r}) - $signed({1'b0, pmin_r});
  assign pct_prod   = t_minus_tl * dpct;
  assign cc_prod    = PERIOD_S * pct_r;

  assign nb      = div_bits(op_r);
  assign dshift  = CW'(DW) - nb;
  assign wb_done = (op_r == OP_CC) || ((op_r == OP_DEG) && !warm_r);
  assign out_free = !out_tvalid_r || out_tready;

  // Operands of each step: numerator P*u - Q*v, or a direct numerator, over divisor den.
  always_comb begin
    p_sel = '0;
    q_sel = KNOT_T0;
    u_sel = d0;
    v_sel = d3;
    num_direct = '0;
    den = '0;
    case (op_r)
      OP_A3: begin
        p_sel = KNOT_T3;
        u_sel = d0;
        v_sel = d3;
        den = DVW'($signed({1'b0, k0_r}) - $signed({1'b0, k3_r}));
      end
      OP_A2: begin
        p_sel = KNOT_T2;
        u_sel = d0;
        v_sel = d2;
        den = DVW'($signed({1'b0, k0_r}) - $signed({1'b0, k2_r}));
      end
      OP_A1: begin
        p_sel = KNOT_T1;
        u_sel = d0;
        v_sel = d1;
        den = DVW'($signed({1'b0, k0_r}) - $signed({1'b0, k1_r}));
      end
      OP_B3: begin
        p_sel = DW'(a3_r);
        q_sel = DW'(a1_r);
        u_sel = d1;
        v_sel = d3;
        den = DVW'($signed({1'b0, k1_r}) - $signed({1'b0, k3_r}));
      end
      OP_B2: begin
        p_sel = DW'(a2_r);
        q_sel = DW'(a1_r);
        u_sel = d1;
        v_sel = d2;
        den = DVW'($signed({1'b0, k1_r}) - $signed({1'b0, k2_r}));
      end
      OP_C: begin
        p_sel = DW'(b3_r);
        q_sel = DW'(b2_r);
        u_sel = d2;
        v_sel = d3;
        den = DVW'($signed({1'b0, k2_r}) - $signed({1'b0, k3_r}));
      end
      OP_DEG: begin
        num_direct = DW'(t_r);
        den = DEG_DIV;
      end
      OP_PCT: begin
        num_direct = DW'(pct_prod);
        den = $signed({1'b0, th_r}) - $signed({1'b0, tl_r});
      end
      OP_CC: begin
        num_direct = DW'(cc_prod);
        den = CC_DIV;
      end
      default: begin
        den = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_tvalid) state_nxt = ST_LOAD;
      ST_LOAD:  state_nxt = op_has_mul(op_r) ? ST_MUL : ST_DLOAD;
      ST_MUL:   if (cnt_r == CW'(XW - 1)) state_nxt = ST_DLOAD;
      ST_DLOAD: state_nxt = (den == '0) ? ST_WB : ST_DIV;
      ST_DIV:   if (cnt_r == nb - 1'b1) state_nxt = ST_WB;
      ST_WB:    state_nxt = wb_done ? ST_OUT : ST_LOAD;
      ST_OUT:   if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = (state_r == ST_IDLE);

    op_nxt = op_r;
    k0_nxt = k0_r;
    k1_nxt = k1_r;
    k2_nxt = k2_r;
    k3_nxt = k3_r;
    pmin_nxt = pmin_r;
    pmax_nxt = pmax_r;
    tl_nxt = tl_r;
    th_nxt = th_r;
    cmp_nxt = cmp_r;
    samp_a_nxt = samp_a_r;
    samp_b_nxt = samp_b_r;
    warm_nxt = warm_r;
    sel_nxt = sel_r;
    a1_nxt = a1_r;
    a2_nxt = a2_r;
    a3_nxt = a3_r;
    b2_nxt = b2_r;
    b3_nxt = b3_r;
    ta_nxt = ta_r;
    t_nxt = t_r;
    deg_nxt = deg_r;
    pct_nxt = pct_r;
    mp_nxt = mp_r;
    mq_nxt = mq_r;
    mu_nxt = mu_r;
    mv_nxt = mv_r;
    acc_nxt = acc_r;
    cnt_nxt = cnt_r;
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    dmag_nxt = dmag_r;
    neg_nxt = neg_r;
    dz_nxt = dz_r;
    out_deg_nxt = out_deg_r;
    out_cmp_nxt = out_cmp_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;

    addp = mu_r[0] ? mp_r : '0;
    addq = mv_r[0] ? mq_r : '0;
    mag = acc_r[DW-1] ? DW'(-acc_r) : DW'(acc_r);
    dneg = -den;
    sh = {rem_r, quo_r[DW-1]};
    diff = {1'b0, sh} - {2'b00, dmag_r};
    ge = !diff[DMW+1];
    res = dz_r ? '0 : (neg_r ? -$signed(quo_r) : $signed(quo_r));
    tmax = (ta_r > res) ? ta_r : res;
    if (tmax < TEMP_MIN) begin
      tsat = TEMP_MIN;
    end else if (tmax > TEMP_MAX) begin
      tsat = TEMP_MAX;
    end else begin
      tsat = tmax;
    end
    cc1 = (res < CC_LO) ? CC_LO : res;
    cc2 = (cc1 > CC_HI) ? CC_HI : cc1;

    if (cfg_valid) begin
      case (cfg_index)
        CFG_KNOT0:    k0_nxt = cfg_data[SW-1:0];
        CFG_KNOT1:    k1_nxt = cfg_data[SW-1:0];
        CFG_KNOT2:    k2_nxt = cfg_data[SW-1:0];
        CFG_KNOT3:    k3_nxt = cfg_data[SW-1:0];
        CFG_PCT_MIN:  pmin_nxt = cfg_data[PCT_CFG_W-1:0];
        CFG_PCT_MAX:  pmax_nxt = cfg_data[PCT_CFG_W-1:0];
        CFG_TEMP_LOW: tl_nxt = cfg_data;
        CFG_TEMP_HI:  th_nxt = cfg_data;
        default:      tl_nxt = tl_r;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          samp_a_nxt = in_tdata[SW-1:0];
          samp_b_nxt = in_tdata[2*SW-1:SW];
          warm_nxt = in_tuser;
          sel_nxt = 1'b0;
          op_nxt = OP_A3;
        end
      end
      ST_LOAD: begin
        mp_nxt = p_sel;
        mq_nxt = q_sel;
        mu_nxt = u_sel;
        mv_nxt = v_sel;
        cnt_nxt = '0;
        acc_nxt = op_has_mul(op_r) ? '0 : num_direct;
      end
      ST_MUL: begin
        // The top bit of a two's complement multiplier carries negative weight.
        acc_nxt = (cnt_r == CW'(XW - 1)) ? acc_r - addp + addq : acc_r + addp - addq;
        mp_nxt = mp_r <<< 1;
        mq_nxt = mq_r <<< 1;
        mu_nxt = mu_r >> 1;
        mv_nxt = mv_r >> 1;
        cnt_nxt = cnt_r + 1'b1;
      end
      ST_DLOAD: begin
        dz_nxt = (den == '0);
        neg_nxt = acc_r[DW-1] ^ den[DVW-1];
        dmag_nxt = den[DVW-1] ? dneg[DMW-1:0] : den[DMW-1:0];
        quo_nxt = mag << dshift;
        rem_nxt = '0;
        cnt_nxt = '0;
      end
      ST_DIV: begin
        rem_nxt = ge ? diff[DMW-1:0] : sh[DMW-1:0];
        quo_nxt = {quo_r[DW-2:0], ge};
        cnt_nxt = cnt_r + 1'b1;
      end
      ST_WB: begin
        case (op_r)
          OP_A3: begin
            a3_nxt = res[AW-1:0];
            op_nxt = OP_A2;
          end
          OP_A2: begin
            a2_nxt = res[AW-1:0];
            op_nxt = OP_A1;
          end
          OP_A1: begin
            a1_nxt = res[AW-1:0];
            op_nxt = OP_B3;
          end
          OP_B3: begin
            b3_nxt = res[BW-1:0];
            op_nxt = OP_B2;
          end
          OP_B2: begin
            b2_nxt = res[BW-1:0];
            op_nxt = OP_C;
          end
          OP_C: begin
            if (!sel_r) begin
              ta_nxt = res;
              sel_nxt = 1'b1;
              op_nxt = OP_A3;
            end else begin
              t_nxt = tsat[TW-1:0];
              op_nxt = OP_DEG;
            end
          end
          OP_DEG: begin
            deg_nxt = res[DEG_W-1:0];
            if (t_below) begin
              pct_nxt = PW'(pmin_r);
              op_nxt = OP_CC;
            end else if (t_above) begin
              pct_nxt = PW'(pmax_r);
              op_nxt = OP_CC;
            end else begin
              op_nxt = OP_PCT;
            end
          end
          OP_PCT: begin
            pct_nxt = res[PW-1:0] + PW'(pmin_r);
            op_nxt = OP_CC;
          end
          OP_CC: begin
            cmp_nxt = (cmp_r < cc2[CMP_W-1:0]) ? cmp_r + 1'b1 : cmp_r - 1'b1;
          end
          default: begin
            op_nxt = OP_A3;
          end
        endcase
      end
      ST_OUT: begin
        if (out_free) begin
          out_deg_nxt = deg_r;
          out_cmp_nxt = cmp_r;
          out_tvalid_nxt = 1'b1;
        end
      end
      default: begin
        op_nxt = OP_A3;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_tvalid_r <= 1'b0;
      cmp_r <= '0;
      k0_r <= SW'(2790);
      k1_r <= SW'(1845);
      k2_r <= SW'(954);
      k3_r <= SW'(331);
      pmin_r <= PCT_CFG_W'(20);
      pmax_r <= PCT_CFG_W'(95);
      tl_r <= 16'd3000;
      th_r <= 16'd4000;
    end else begin
      state_r <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      cmp_r <= cmp_nxt;
      k0_r <= k0_nxt;
      k1_r <= k1_nxt;
      k2_r <= k2_nxt;
      k3_r <= k3_nxt;
      pmin_r <= pmin_nxt;
      pmax_r <= pmax_nxt;
      tl_r <= tl_nxt;
      th_r <= th_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt;
    samp_a_r <= samp_a_nxt;
    samp_b_r <= samp_b_nxt;
    warm_r <= warm_nxt;
    sel_r <= sel_nxt;
    a1_r <= a1_nxt;
    a2_r <= a2_nxt;
    a3_r <= a3_nxt;
    b2_r <= b2_nxt;
    b3_r <= b3_nxt;
    ta_r <= ta_nxt;
    t_r <= t_nxt;
    deg_r <= deg_nxt;
    pct_r <= pct_nxt;
    mp_r <= mp_nxt;
    mq_r <= mq_nxt;
    mu_r <= mu_nxt;
    mv_r <= mv_nxt;
    acc_r <= acc_nxt;
    cnt_r <= cnt_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dmag_r <= dmag_nxt;
    neg_r <= neg_nxt;
    dz_r <= dz_nxt;
    out_deg_r <= out_deg_nxt;
    out_cmp_r <= out_cmp_nxt;
  end

endmodule
